// ===== src/m4tc_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, constants and codes for the 4x4 transform composer.
package m4tc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIM_DEF       = 4;
  localparam int W             = 32;
  localparam int NCELL         = 16;
  localparam int ACC_W         = 64;

  typedef enum logic [2:0] {
    OP_IDENT  = 3'd0,
    OP_TRANS  = 3'd1,
    OP_SCALE  = 3'd2,
    OP_QUAT   = 3'd3,
    OP_LOAD   = 3'd4,
    OP_MUL    = 3'd5,
    OP_READ   = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUAT,
    ST_MAC,
    ST_COPY,
    ST_READ
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       capture;   // latch the input item
    logic       ident;     // current matrix to identity
    logic       load;      // write one operand element
    logic       quat_step; // one quaternion product
    logic [3:0] qidx;      // which quaternion product
    logic       mac;       // one multiply-accumulate
    logic [5:0] midx;      // {i, j, k}
    logic       copy;      // result matrix into current
    logic [3:0] ridx;      // read-out element
  } ctl_t;

  function automatic logic signed [W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] mx;
    logic signed [ACC_W-1:0] mn;
    mx = ACC_W'(64'sh7FFFFFFF);
    mn = -ACC_W'(64'sh80000000);
    if (v > mx) return 32'sh7FFFFFFF;
    else if (v < mn) return 32'sh80000000;
    else return v[W-1:0];
  endfunction

endpackage

// ===== src/m4tc_if.sv =====
`timescale 1ns / 1ps
// Interfaces: input item channel and result channel.
interface m4tc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [1:0]  row;
  logic [1:0]  col;
  logic signed [31:0] val_a;
  logic signed [31:0] val_b;
  logic signed [31:0] val_c;
  logic signed [31:0] val_d;
  modport source (output valid, op, row, col, val_a, val_b, val_c, val_d, input ready);
  modport sink (input valid, op, row, col, val_a, val_b, val_c, val_d, output ready);
endinterface

interface m4tc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  elem_row;
  logic [1:0]  elem_col;
  logic signed [31:0] elem_value;
  logic        last;
  modport source (output valid, elem_row, elem_col, elem_value, last, input ready);
  modport sink (input valid, elem_row, elem_col, elem_value, last, output ready);
endinterface

// ===== src/m4tc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences quaternion products, multiply-accumulates and read-out.
module m4tc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_last,
  output m4tc_pkg::ctl_t      ctl
);
  import m4tc_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       acc_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    ctl.qidx  = cnt_r[3:0];
    ctl.midx  = cnt_r;
    ctl.ridx  = cnt_r[3:0];
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    acc_v     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        acc_v    = in_valid;
        if (acc_v) begin
          ctl.capture = 1'b1;
          cnt_nxt     = '0;
          case (op_t'(in_op))
            OP_IDENT: ctl.ident = 1'b1;
            OP_LOAD:  ctl.load  = 1'b1;
            OP_TRANS, OP_SCALE, OP_MUL: state_nxt = ST_MAC;
            OP_QUAT:  state_nxt = ST_QUAT;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_QUAT: begin
        ctl.quat_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd8) begin
          cnt_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        ctl.mac = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = ST_COPY;
      end
      ST_COPY: begin
        ctl.copy  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        out_valid = 1'b1;
        out_last  = (cnt_r[3:0] == 4'd15);
        if (out_ready) begin
          cnt_nxt = cnt_r + 6'd1;
          if (out_last) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> state_r == ST_IDLE) else $error("read did not end");
  a_mac_copy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC && cnt_r == 6'd63 |=> state_r == ST_COPY) else $error("mac overrun");
`endif
endmodule

// ===== src/m4tc_dp.sv =====
`timescale 1ns / 1ps
// Datapath: matrices, one shared multiplier and the accumulator.
module m4tc_dp #(
  parameter int FRAC_BITS = m4tc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  m4tc_pkg::ctl_t      ctl,
  input  logic [2:0]          in_op,
  input  logic [1:0]          in_row,
  input  logic [1:0]          in_col,
  input  logic signed [31:0]  in_a,
  input  logic signed [31:0]  in_b,
  input  logic signed [31:0]  in_c,
  input  logic signed [31:0]  in_d,
  output logic signed [31:0]  rd_value
);
  import m4tc_pkg::*;

  localparam logic signed [W-1:0] ONE = W'(64'sd1 << FRAC_BITS);

  logic signed [W-1:0] cur_r [NCELL];
  logic signed [W-1:0] opm_r [NCELL];
  logic signed [W-1:0] res_r [NCELL];
  logic signed [ACC_W-1:0] q_r [9];
  logic signed [W-1:0] a_r, b_r, c_r, d_r;
  logic [2:0]          op_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [1:0] mi, mj, mk;
  logic signed [W-1:0] ma, mb, ea, eb;
  logic signed [63:0]  prod;
  logic signed [ACC_W-1:0] pfl, accs;
  logic signed [ACC_W-1:0] one_w;

  assign mi = ctl.midx[5:4];
  assign mj = ctl.midx[3:2];
  assign mk = ctl.midx[1:0];
  assign one_w = ACC_W'(ONE);

  // Element of the quaternion rotation matrix, the right-hand matrix for a rotate.
  function automatic logic signed [W-1:0] rot(input logic [1:0] r, input logic [1:0] c);
    logic signed [ACC_W-1:0] t;
    t = '0;
    // q order: xx yy zz xy xz yz wx wy wz
    case ({r, c})
      4'h0: t = one_w - 2 * (ACC_W'(q_r[1]) + ACC_W'(q_r[2]));
      4'h1: t = 2 * (ACC_W'(q_r[3]) + ACC_W'(q_r[8]));
      4'h2: t = 2 * (ACC_W'(q_r[4]) - ACC_W'(q_r[7]));
      4'h4: t = 2 * (ACC_W'(q_r[3]) - ACC_W'(q_r[8]));
      4'h5: t = one_w - 2 * (ACC_W'(q_r[0]) + ACC_W'(q_r[2]));
      4'h6: t = 2 * (ACC_W'(q_r[6]) + ACC_W'(q_r[5]));
      4'h8: t = 2 * (ACC_W'(q_r[7]) + ACC_W'(q_r[4]));
      4'h9: t = 2 * (ACC_W'(q_r[5]) - ACC_W'(q_r[6]));
      4'hA: t = one_w - 2 * (ACC_W'(q_r[0]) + ACC_W'(q_r[1]));
      4'hF: t = one_w;
      default: t = '0;
    endcase
    return sat32(t);
  endfunction

  always_comb begin
    eb = (mk == mj) ? ONE : '0;
    case (op_t'(op_r))
      OP_TRANS: if (mk == 2'd3 && mj != 2'd3)
                  eb = (mj == 2'd0) ? a_r : (mj == 2'd1) ? b_r : c_r;
      OP_SCALE: if (mk == mj && mj != 2'd3)
                  eb = (mj == 2'd0) ? a_r : (mj == 2'd1) ? b_r : c_r;
      OP_QUAT:  eb = rot(mk, mj);
      OP_MUL:   eb = opm_r[{mk, mj}];
      default:  eb = (mk == mj) ? ONE : '0;
    endcase
    ea = cur_r[{mi, mk}];
    case (ctl.qidx)
      4'd0: begin ma = a_r; mb = a_r; end
      4'd1: begin ma = b_r; mb = b_r; end
      4'd2: begin ma = c_r; mb = c_r; end
      4'd3: begin ma = a_r; mb = b_r; end
      4'd4: begin ma = a_r; mb = c_r; end
      4'd5: begin ma = b_r; mb = c_r; end
      4'd6: begin ma = d_r; mb = a_r; end
      4'd7: begin ma = d_r; mb = b_r; end
      default: begin ma = d_r; mb = c_r; end
    endcase
    if (ctl.mac) begin
      ma = ea;
      mb = eb;
    end
    prod = 64'(ma) * 64'(mb);
    pfl  = ACC_W'(prod >>> FRAC_BITS);
    accs = (mk == 2'd0) ? pfl : acc_r + pfl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NCELL; n++) begin
        cur_r[n] <= (n % 5 == 0) ? ONE : '0;
        opm_r[n] <= '0;
      end
    end else begin
      if (ctl.ident)
        for (int n = 0; n < NCELL; n++) cur_r[n] <= (n % 5 == 0) ? ONE : '0;
      if (ctl.load) opm_r[{in_row, in_col}] <= in_a;
      if (ctl.copy)
        for (int n = 0; n < NCELL; n++) cur_r[n] <= res_r[n];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r <= in_op;
      a_r  <= in_a;
      b_r  <= in_b;
      c_r  <= in_c;
      d_r  <= in_d;
    end
    if (ctl.quat_step) q_r[ctl.qidx] <= pfl;
    if (ctl.mac) begin
      acc_r <= accs;
      if (mk == 2'd3) res_r[{mi, mj}] <= sat32(accs);
    end
  end

  assign rd_value = cur_r[ctl.ridx];

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({ctl.capture, ctl.quat_step, ctl.mac, ctl.copy}) <= 1) else $error("overlap");
  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ident |=> cur_r[0] == ONE) else $error("identity not set");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> ctl.capture) else $error("load without capture");
`endif
endmodule

// ===== src/mat4_transform_composer_unit.sv =====
`timescale 1ns / 1ps
// Top level: 4x4 fixed-point transform composer.
// Identity and operand load are applied as the item is taken. In translate, scale,
// multiply and quaternion rotate the 64 multiply-accumulates of a 4x4 product pass one
// at a time through one shared 32x32 multiplier; the quaternion first computes its nine
// products in the same multiplier. A read gives one element transfer per cycle while the
// sink is ready. One item is in work at a time.
module mat4_transform_composer_unit #(
  parameter int FRAC_BITS = m4tc_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  m4tc_in_if.sink    in_ch,
  m4tc_out_if.source out_ch
);
  import m4tc_pkg::*;

  ctl_t ctl;
  logic signed [31:0] rd_value;

  m4tc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last),
    .ctl(ctl)
  );

  m4tc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .in_op(in_ch.op), .in_row(in_ch.row), .in_col(in_ch.col),
    .in_a(in_ch.val_a), .in_b(in_ch.val_b), .in_c(in_ch.val_c), .in_d(in_ch.val_d),
    .rd_value(rd_value)
  );

  assign out_ch.elem_row   = ctl.ridx[3:2];
  assign out_ch.elem_col   = ctl.ridx[1:0];
  assign out_ch.elem_value = rd_value;
endmodule

// ===== verif/tb_mat4_transform_composer_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the 4x4 fixed-point transform composer, with its own matrix model.
module tb_mat4_transform_composer_unit;
  import m4tc_pkg::*;

  typedef struct packed {
    logic [1:0]         elem_row;
    logic [1:0]         elem_col;
    logic signed [31:0] elem_value;
    logic               last;
  } elem_t;

  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;
  m4tc_in_if  in_ch ();
  m4tc_out_if out_ch ();

  mat4_transform_composer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logic signed [63:0] cur_mat [16];
  logic signed [63:0] opnd_mat [16];
  elem_t              pending_elems [$];
  int                 mismatches;
  int                 idle_cycles;
  int                 ready_gap;
  bit                 calm;
  bit                 timed_out;

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic load_identity(output logic signed [63:0] m [16]);
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 64'sd65536 : 64'sd0;
  endtask

  task automatic compose(input logic signed [63:0] m [16]);
    logic signed [63:0] res [16];
    logic signed [63:0] acc;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += fx_mul(cur_mat[i*4+k], m[k*4+j]);
        res[i*4+j] = clamp32(acc);
      end
    cur_mat = res;
  endtask

  task automatic predict_item(op_t op, logic [1:0] r, logic [1:0] c,
                              logic signed [31:0] a, logic signed [31:0] b,
                              logic signed [31:0] z, logic signed [31:0] w);
    logic signed [63:0] m [16];
    logic signed [63:0] xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
    elem_t e;
    one = 64'sd65536;
    load_identity(m);
    case (op)
      OP_IDENT: load_identity(cur_mat);
      OP_TRANS: begin
        m[12] = a; m[13] = b; m[14] = z;
        compose(m);
      end
      OP_SCALE: begin
        m[0] = a; m[5] = b; m[10] = z;
        compose(m);
      end
      OP_QUAT: begin
        xx = fx_mul(a, a); yy = fx_mul(b, b); zz = fx_mul(z, z);
        xy = fx_mul(a, b); xz = fx_mul(a, z); yz = fx_mul(b, z);
        wx = fx_mul(w, a); wy = fx_mul(w, b); wz = fx_mul(w, z);
        m[0]  = clamp32(one - 2 * (yy + zz));
        m[1]  = clamp32(2 * (xy + wz));
        m[2]  = clamp32(2 * (xz - wy));
        m[4]  = clamp32(2 * (xy - wz));
        m[5]  = clamp32(one - 2 * (xx + zz));
        m[6]  = clamp32(2 * (wx + yz));
        m[8]  = clamp32(2 * (wy + xz));
        m[9]  = clamp32(2 * (yz - wx));
        m[10] = clamp32(one - 2 * (xx + yy));
        compose(m);
      end
      OP_LOAD: opnd_mat[r*4+c] = a;
      OP_MUL: compose(opnd_mat);
      OP_READ:
        for (int i = 0; i < 16; i++) begin
          e.elem_row   = 2'(i / 4);
          e.elem_col   = 2'(i % 4);
          e.elem_value = cur_mat[i][31:0];
          e.last       = (i == 15);
          pending_elems.push_back(e);
        end
      default: ;
    endcase
  endtask

  task automatic send_item(op_t op, logic [1:0] r = 0, logic [1:0] c = 0,
                           logic signed [31:0] a = 0, logic signed [31:0] b = 0,
                           logic signed [31:0] z = 0, logic signed [31:0] w = 0);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.row   <= r;
    in_ch.col   <= c;
    in_ch.val_a <= a;
    in_ch.val_b <= b;
    in_ch.val_c <= z;
    in_ch.val_d <= w;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(op, r, c, a, b, z, w);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 262143)) - 131072);
      2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return 32'(int'($urandom_range(0, 196608)) - 98304);
    endcase
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_item(OP_READ);
    send_item(OP_SCALE, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000);
    send_item(OP_READ);
    send_item(OP_SCALE, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    send_item(OP_READ);
    send_item(OP_IDENT);
    send_item(OP_TRANS, 3, 3, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 32'sh7FFFFFFF);
    send_item(OP_READ);
  endtask

  task automatic test_quaternion();
    send_item(OP_IDENT);
    send_item(OP_QUAT, 0, 0, 32'sh0000B505, 0, 0, 32'sh0000B505);
    send_item(OP_QUAT, 0, 0, 32'sh00020000, 32'sh00030000, -32'sh00010000, 32'sh00008000);
    send_item(OP_READ);
    send_item(OP_QUAT, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_item(OP_READ);
  endtask

  task automatic test_operand();
    for (int i = 0; i < 16; i++) send_item(OP_LOAD, 2'(i / 4), 2'(i % 4), rand_q());
    send_item(OP_NONE, 1, 2, 32'sh12345678, -32'sd5, 32'sd7, 32'sd9);
    send_item(OP_MUL);
    send_item(OP_READ);
  endtask

  task automatic test_full_pause();
    drain();
    send_item(OP_READ);
  endtask

  task automatic test_random(int count);
    op_t op;
    for (int n = 0; n < count; n++) begin
      if (n == count - 60) calm = 1'b1;
      op = op_t'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) op = OP_LOAD;
      send_item(op, 2'($urandom), 2'($urandom), rand_q(), rand_q(), rand_q(), rand_q());
      if ($urandom_range(0, 9) == 0) send_item(OP_IDENT);
    end
    send_item(OP_READ);
  endtask

  always @(posedge clk) begin
    elem_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_gap    <= 0;
    end else begin
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (ready_gap > 0) begin
        ready_gap    <= ready_gap - 1;
        out_ch.ready <= (ready_gap == 1);
      end else if ($urandom_range(0, 5) == 0) begin
        ready_gap    <= $urandom_range(1, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.elem_row, out_ch.elem_col, out_ch.elem_value, out_ch.last};
        if (pending_elems.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected transfer: %p", got);
        end else begin
          want = pending_elems.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    calm         = 1'b0;
    timed_out    = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_IDENT;
    in_ch.row    = 0;
    in_ch.col    = 0;
    in_ch.val_a  = 0;
    in_ch.val_b  = 0;
    in_ch.val_c  = 0;
    in_ch.val_d  = 0;
    out_ch.ready = 1'b0;
    load_identity(cur_mat);
    for (int i = 0; i < 16; i++) opnd_mat[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_quaternion();
    test_operand();
    test_full_pause();
    test_random(300);
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_elems.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
